[hw/rtl/orot_pkg.sv]
// Shared types and constants for the oriented rectangle overlap test.
// Used by orot_axis and oriented_rectangle_overlap_test_top; no dependencies.
package orot_pkg;

  // Coordinate width of every input corner field.
  localparam int COORD_W  = 16;
  // An edge axis is a difference of two corners.
  localparam int AXIS_W   = COORD_W + 1;
  // The fourth corner is c0 + c2 - c1.
  localparam int CORNER_W = COORD_W + 2;
  // One product and the sum of two products.
  localparam int PROD_W   = AXIS_W + CORNER_W;
  localparam int DOT_W    = PROD_W + 1;

  // Configuration port.
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam logic REG_IDX_MODE = 1'b0;

  typedef struct packed {
    logic signed [CORNER_W-1:0] x;
    logic signed [CORNER_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
  } axis_t;

  typedef point_t [3:0] rect_t;

endpackage

[hw/rtl/oriented_rectangle_overlap_test_top.sv]
// Top level of the oriented rectangle overlap test (separating axis test).
// Depends on orot_pkg and orot_axis.
//
// Usage:
//   An item (two rectangles, three corners each) is accepted at a rising
//   edge where start is high and busy is low. busy is always low, so one
//   item can be accepted every cycle.
//   The result overlap_o is shown for one cycle with done_o high.
//   Results leave in accept order.
//   The pipeline is five register stages: input capture, corner and axis
//   build, projections (two multipliers per corner per axis), interval
//   bounds, and the result register. Four axis lanes run in parallel.
//   The receiver cannot stall; done_o is never held.
//   The mode register (APB, address 0, bit 0) selects whether the second
//   rectangle's axes are tested too; it resets to 1 and must only be
//   written while no item is in flight.
//   Reset clears the valid pipeline and restores the mode register.
module oriented_rectangle_overlap_test_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [orot_pkg::COORD_W-1:0]  a_corner0_x_i,
  input  logic signed [orot_pkg::COORD_W-1:0]  a_corner0_y_i,
  input  logic signed [orot_pkg::COORD_W-1:0]  a_corner1_x_i,
  input  logic signed [orot_pkg::COORD_W-1:0]  a_corner1_y_i,
  input  logic signed [orot_pkg::COORD_W-1:0]  a_corner2_x_i,
  input  logic signed [orot_pkg::COORD_W-1:0]  a_corner2_y_i,
  input  logic signed [orot_pkg::COORD_W-1:0]  b_corner0_x_i,
  input  logic signed [orot_pkg::COORD_W-1:0]  b_corner0_y_i,
  input  logic signed [orot_pkg::COORD_W-1:0]  b_corner1_x_i,
  input  logic signed [orot_pkg::COORD_W-1:0]  b_corner1_y_i,
  input  logic signed [orot_pkg::COORD_W-1:0]  b_corner2_x_i,
  input  logic signed [orot_pkg::COORD_W-1:0]  b_corner2_y_i,
  output logic                                 done_o,
  output logic                                 overlap_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [orot_pkg::PADDR_W-1:0]         paddr,
  input  logic [orot_pkg::PDATA_W-1:0]         pwdata,
  output logic [orot_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready
);
  import orot_pkg::*;

  logic accept;
  logic mode_q;
  logic reg_wr;
  logic [3:0] valid_q;
  logic done_q, overlap_q, overlap_d;

  logic signed [COORD_W-1:0] in_q [12];
  rect_t rect_a_d, rect_b_d, rect_a_q, rect_b_q;
  axis_t axis_d [4];
  axis_t axis_q [4];
  logic [3:0] sep;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start & ~busy;

  // Configuration register.
  assign reg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_IDX_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (reg_wr) begin
      mode_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_IDX_MODE) ? {{(PDATA_W-1){1'b0}}, mode_q} : '0;

  // Valid pipeline: input, build, projection, bounds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= {valid_q[2:0], accept};
      done_q  <= valid_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q[0]  <= a_corner0_x_i;
      in_q[1]  <= a_corner0_y_i;
      in_q[2]  <= a_corner1_x_i;
      in_q[3]  <= a_corner1_y_i;
      in_q[4]  <= a_corner2_x_i;
      in_q[5]  <= a_corner2_y_i;
      in_q[6]  <= b_corner0_x_i;
      in_q[7]  <= b_corner0_y_i;
      in_q[8]  <= b_corner1_x_i;
      in_q[9]  <= b_corner1_y_i;
      in_q[10] <= b_corner2_x_i;
      in_q[11] <= b_corner2_y_i;
    end
  end

  // Corners (the fourth is c0 + c2 - c1) and the edge axes c1-c0, c1-c2.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rect_a_d[i].x = CORNER_W'(in_q[2*i]);
      rect_a_d[i].y = CORNER_W'(in_q[2*i+1]);
      rect_b_d[i].x = CORNER_W'(in_q[6+2*i]);
      rect_b_d[i].y = CORNER_W'(in_q[7+2*i]);
    end
    rect_a_d[3].x = rect_a_d[0].x + rect_a_d[2].x - rect_a_d[1].x;
    rect_a_d[3].y = rect_a_d[0].y + rect_a_d[2].y - rect_a_d[1].y;
    rect_b_d[3].x = rect_b_d[0].x + rect_b_d[2].x - rect_b_d[1].x;
    rect_b_d[3].y = rect_b_d[0].y + rect_b_d[2].y - rect_b_d[1].y;

    axis_d[0].x = AXIS_W'(in_q[2])  - AXIS_W'(in_q[0]);
    axis_d[0].y = AXIS_W'(in_q[3])  - AXIS_W'(in_q[1]);
    axis_d[1].x = AXIS_W'(in_q[2])  - AXIS_W'(in_q[4]);
    axis_d[1].y = AXIS_W'(in_q[3])  - AXIS_W'(in_q[5]);
    axis_d[2].x = AXIS_W'(in_q[8])  - AXIS_W'(in_q[6]);
    axis_d[2].y = AXIS_W'(in_q[9])  - AXIS_W'(in_q[7]);
    axis_d[3].x = AXIS_W'(in_q[8])  - AXIS_W'(in_q[10]);
    axis_d[3].y = AXIS_W'(in_q[9])  - AXIS_W'(in_q[11]);
  end

  always_ff @(posedge clk_i) begin
    rect_a_q <= rect_a_d;
    rect_b_q <= rect_b_d;
    axis_q   <= axis_d;
  end

  for (genvar k = 0; k < 4; k++) begin : g_axis
    orot_axis u_axis (
      .clk_i    (clk_i),
      .axis_i   (axis_q[k]),
      .rect_a_i (rect_a_q),
      .rect_b_i (rect_b_q),
      .sep_o    (sep[k])
    );
  end

  // The second rectangle's axes only count when the mode bit is set.
  assign overlap_d = ~(sep[0] | sep[1]) & ~(mode_q & (sep[2] | sep[3]));

  always_ff @(posedge clk_i) begin
    overlap_q <= overlap_d;
  end

  assign done_o    = done_q;
  assign overlap_o = overlap_q;

endmodule

[hw/rtl/orot_axis.sv]
// One separating axis lane: projects both rectangles onto one axis and
// compares the intervals. Two register stages. Depends on orot_pkg.
module orot_axis (
  input  logic           clk_i,
  input  orot_pkg::axis_t axis_i,
  input  orot_pkg::rect_t rect_a_i,
  input  orot_pkg::rect_t rect_b_i,
  output logic           sep_o
);
  import orot_pkg::*;

  logic signed [DOT_W-1:0] dot_a_d [4];
  logic signed [DOT_W-1:0] dot_b_d [4];
  logic signed [DOT_W-1:0] dot_a_q [4];
  logic signed [DOT_W-1:0] dot_b_q [4];

  logic signed [DOT_W-1:0] a_lo_d, a_hi_d, b_lo_d, b_hi_d;
  logic signed [DOT_W-1:0] a_lo_q, a_hi_q, b_lo_q, b_hi_q;

  // Projection of each corner onto the unnormalized axis.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dot_a_d[i] = DOT_W'(PROD_W'(axis_i.x) * PROD_W'(rect_a_i[i].x))
                 + DOT_W'(PROD_W'(axis_i.y) * PROD_W'(rect_a_i[i].y));
      dot_b_d[i] = DOT_W'(PROD_W'(axis_i.x) * PROD_W'(rect_b_i[i].x))
                 + DOT_W'(PROD_W'(axis_i.y) * PROD_W'(rect_b_i[i].y));
    end
  end

  always_ff @(posedge clk_i) begin
    dot_a_q <= dot_a_d;
    dot_b_q <= dot_b_d;
  end

  always_comb begin
    a_lo_d = dot_a_q[0];
    a_hi_d = dot_a_q[0];
    b_lo_d = dot_b_q[0];
    b_hi_d = dot_b_q[0];
    for (int i = 1; i < 4; i++) begin
      if (dot_a_q[i] < a_lo_d) a_lo_d = dot_a_q[i];
      if (dot_a_q[i] > a_hi_d) a_hi_d = dot_a_q[i];
      if (dot_b_q[i] < b_lo_d) b_lo_d = dot_b_q[i];
      if (dot_b_q[i] > b_hi_d) b_hi_d = dot_b_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    a_lo_q <= a_lo_d;
    a_hi_q <= a_hi_d;
    b_lo_q <= b_lo_d;
    b_hi_q <= b_hi_d;
  end

  // Intervals that only touch still count as meeting.
  assign sep_o = (b_lo_q > a_hi_q) || (b_hi_q < a_lo_q);

endmodule

[sim/overlap_monitor.sv]
// Result checker for the oriented rectangle overlap test: watches the item, result and APB
// channels, predicts each overlap bit and compares it with what the block returns.
// Depends on orot_pkg for the coordinate and APB widths.
`timescale 1ns / 1ps

module overlap_monitor (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic                                    busy_i,
  input  logic [11:0][orot_pkg::COORD_W-1:0]      corners_i,
  input  logic                                    done_i,
  input  logic                                    overlap_i,
  input  logic                                    psel_i,
  input  logic                                    penable_i,
  input  logic                                    pwrite_i,
  input  logic                                    pready_i,
  input  logic [orot_pkg::PADDR_W-1:0]            paddr_i,
  input  logic [orot_pkg::PDATA_W-1:0]            pwdata_i,
  input  logic [orot_pkg::PDATA_W-1:0]            prdata_i,
  output int                                      fail_count_o,
  output int                                      pending_o
);
  import orot_pkg::*;

  bit test_both_axes;
  bit overlap_expect_q[$];

  // Projects four corners onto an unnormalized axis and returns the interval bounds.
  function automatic void project_span(input longint xs[4], input longint ys[4],
                                       input longint dx, input longint dy,
                                       output longint lo, output longint hi);
    longint d;
    lo = dx * xs[0] + dy * ys[0];
    hi = lo;
    for (int i = 1; i < 4; i++) begin
      d = dx * xs[i] + dy * ys[i];
      if (d > hi) hi = d;
      if (d < lo) lo = d;
    end
  endfunction

  // True when either edge axis of the own rectangle splits the pair.
  function automatic bit edge_axes_separate(input longint ox[4], input longint oy[4],
                                            input longint px[4], input longint py[4]);
    longint dx[2];
    longint dy[2];
    longint olo, ohi, plo, phi;
    dx[0] = ox[1] - ox[0];
    dy[0] = oy[1] - oy[0];
    dx[1] = ox[1] - ox[2];
    dy[1] = oy[1] - oy[2];
    for (int k = 0; k < 2; k++) begin
      project_span(ox, oy, dx[k], dy[k], olo, ohi);
      project_span(px, py, dx[k], dy[k], plo, phi);
      // Intervals that only touch still count as meeting.
      if (plo > ohi || phi < olo) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit predict_overlap(input logic [11:0][COORD_W-1:0] c, input bit both);
    longint ax[4], ay[4], bx[4], by[4];
    bit hit;
    for (int i = 0; i < 3; i++) begin
      ax[i] = $signed(c[2*i]);
      ay[i] = $signed(c[2*i+1]);
      bx[i] = $signed(c[6+2*i]);
      by[i] = $signed(c[7+2*i]);
    end
    ax[3] = ax[0] + ax[2] - ax[1];
    ay[3] = ay[0] + ay[2] - ay[1];
    bx[3] = bx[0] + bx[2] - bx[1];
    by[3] = by[0] + by[2] - by[1];
    hit = !edge_axes_separate(ax, ay, bx, by);
    if (hit && both) hit = !edge_axes_separate(bx, by, ax, ay);
    return hit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      test_both_axes = 1'b1;
      overlap_expect_q.delete();
      pending_o = 0;
      fail_count_o = 0;
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i[PADDR_W-1:2] == REG_IDX_MODE) begin
        if (pwrite_i) begin
          test_both_axes = pwdata_i[0];
        end else if (prdata_i !== {{(PDATA_W-1){1'b0}}, test_both_axes}) begin
          $display("%0t mode register read mismatch: expected %0h actual %0h",
                   $time, {{(PDATA_W-1){1'b0}}, test_both_axes}, prdata_i);
          fail_count_o++;
        end
      end
      if (start_i && !busy_i)
        overlap_expect_q.push_back(predict_overlap(corners_i, test_both_axes));
      if (done_i === 1'b1) begin
        if (overlap_expect_q.size() == 0) begin
          $display("%0t unexpected result: expected none actual overlap=%0b",
                   $time, overlap_i);
          fail_count_o++;
        end else if (overlap_i !== overlap_expect_q[0]) begin
          $display("%0t overlap mismatch: expected %0b actual %0b",
                   $time, overlap_expect_q[0], overlap_i);
          fail_count_o++;
          void'(overlap_expect_q.pop_front());
        end else begin
          void'(overlap_expect_q.pop_front());
        end
      end else if (done_i !== 1'b0) begin
        $display("%0t done strobe unknown: expected 0 or 1 actual %b", $time, done_i);
        fail_count_o++;
      end
      pending_o = overlap_expect_q.size();
    end
  end

endmodule

[sim/tb_oriented_rectangle_overlap_test_top.sv]
// Testbench top for oriented_rectangle_overlap_test_top: drives rectangle pairs and APB
// mode writes in phases, and gives the verdict from the count kept by overlap_monitor.
// Depends on orot_pkg, the block itself and overlap_monitor.
`timescale 1ns / 1ps

module tb_oriented_rectangle_overlap_test_top;
  import orot_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 220;
  localparam logic [PADDR_W-1:0] ADDR_MODE = {REG_IDX_MODE, 2'b00};
  // Index 1 has no register behind it; writes there must be dropped.
  localparam logic [PADDR_W-1:0] ADDR_SPARE = {1'b1, 2'b00};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [11:0][COORD_W-1:0] pair_q = '0;
  logic done_o;
  logic overlap_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  int fail_count;
  int pending;
  int cycles = 0;

  always #10 clk_i = ~clk_i;

  oriented_rectangle_overlap_test_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .a_corner0_x_i (pair_q[0]),
    .a_corner0_y_i (pair_q[1]),
    .a_corner1_x_i (pair_q[2]),
    .a_corner1_y_i (pair_q[3]),
    .a_corner2_x_i (pair_q[4]),
    .a_corner2_y_i (pair_q[5]),
    .b_corner0_x_i (pair_q[6]),
    .b_corner0_y_i (pair_q[7]),
    .b_corner1_x_i (pair_q[8]),
    .b_corner1_y_i (pair_q[9]),
    .b_corner2_x_i (pair_q[10]),
    .b_corner2_y_i (pair_q[11]),
    .done_o        (done_o),
    .overlap_o     (overlap_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  overlap_monitor monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .corners_i    (pair_q),
    .done_i       (done_o),
    .overlap_i    (overlap_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int spread(input int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  // Rectangle from a start corner, an integer direction and its perpendicular.
  function automatic logic [5:0][COORD_W-1:0] make_rect(input int ox, input int oy,
                                                        input int dmax, input int kmax);
    int a, b, k1, k2, x1, y1;
    logic [5:0][COORD_W-1:0] r;
    a = spread(dmax);
    b = spread(dmax);
    k1 = $urandom_range(0, kmax);
    k2 = $urandom_range(0, kmax);
    if ($urandom_range(0, 19) == 0) k1 = 0;
    x1 = ox + a * k1;
    y1 = oy + b * k1;
    r[0] = COORD_W'(ox);
    r[1] = COORD_W'(oy);
    r[2] = COORD_W'(x1);
    r[3] = COORD_W'(y1);
    r[4] = COORD_W'(x1 - b * k2);
    r[5] = COORD_W'(y1 + a * k2);
    return r;
  endfunction

  function automatic logic [11:0][COORD_W-1:0] random_pair();
    int kind, dmax, kmax, span, ox, oy;
    logic [11:0][COORD_W-1:0] p;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      for (int i = 0; i < 12; i++) p[i] = COORD_W'($urandom);
      return p;
    end
    if (kind < 30) begin
      dmax = 3;  kmax = 3;   span = 12;
    end else if (kind < 85) begin
      dmax = 20; kmax = 25;  span = 1200;
    end else begin
      dmax = 60; kmax = 120; span = 9000;
    end
    ox = spread(6000);
    oy = spread(6000);
    p[5:0] = make_rect(ox, oy, dmax, kmax);
    p[11:6] = make_rect(ox + spread(span), oy + spread(span), dmax, kmax);
    return p;
  endfunction

  function automatic logic [11:0][COORD_W-1:0] directed_pair(input int idx);
    int v[12];
    logic [11:0][COORD_W-1:0] p;
    case (idx)
      0:  v = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      1:  v = '{32767, 32767, 32767, 32767, 32767, 32767,
                32767, 32767, 32767, 32767, 32767, 32767};
      2:  v = '{-32768, -32768, -32768, -32768, -32768, -32768,
                -32768, -32768, -32768, -32768, -32768, -32768};
      3:  v = '{-32768, -32768, 32767, -32768, 32767, 32767,
                -32768, -32768, 32767, -32768, 32767, 32767};
      4:  v = '{-32768, -32768, 32767, -32768, 32767, 32767,
                32767, 32767, -32768, 32767, -32768, -32768};
      5:  v = '{-32768, -32768, -32758, -32768, -32758, -32758,
                32757, 32757, 32767, 32757, 32767, 32767};
      // Shared edge, one unit gap, shared corner only.
      6:  v = '{0, 0, 10, 0, 10, 10, 10, 0, 20, 0, 20, 10};
      7:  v = '{0, 0, 10, 0, 10, 10, 11, 0, 21, 0, 21, 10};
      8:  v = '{0, 0, 10, 0, 10, 10, 10, 10, 20, 10, 20, 20};
      // Diamond near a corner: only its own diagonal axis separates.
      9:  v = '{0, 0, 10, 0, 10, 10, 12, 9, 15, 12, 12, 15};
      // Collapsed rectangles: every axis of the point is the zero vector.
      10: v = '{5, 5, 5, 5, 5, 5, 0, 0, 10, 0, 10, 10};
      11: v = '{0, 0, 10, 0, 10, 10, 30, 30, 30, 30, 30, 30};
      12: v = '{0, 0, 10, 3, 4, 9, -5, -20, 7, -2, -20, 30};
      13: v = '{-20000, 0, 0, -20000, 20000, 0, 15000, 15000, 30000, 0, 32767, 32767};
      default: v = '{-100, -100, 100, -100, 100, 100, -5, -5, 5, -5, 5, 5};
    endcase
    for (int i = 0; i < 12; i++) p[i] = COORD_W'(v[i]);
    return p;
  endfunction

  // Holds start high with a new item until the block takes it.
  task automatic send_pair(input logic [11:0][COORD_W-1:0] p);
    start <= 1'b1;
    pair_q <= p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    pause(1);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_directed(input int first, input int last);
    for (int i = first; i <= last; i++) begin
      send_pair(directed_pair(i));
      if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 4));
    end
  endtask

  task automatic run_random(input int n);
    int burst_left;
    burst_left = $urandom_range(1, 16);
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        pause($urandom_range(1, 12));
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 16);
      end
      send_pair(random_pair());
      burst_left--;
    end
    drain();
  endtask

  task automatic mode_phase(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    apb_access(1'b1, addr, data);
    apb_access(1'b0, ADDR_MODE, '0);
    run_random(RANDOM_PER_PHASE);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Reset value of the mode register, then all four axes.
    apb_access(1'b0, ADDR_MODE, '0);
    run_directed(0, 14);
    run_random(RANDOM_PER_PHASE);
    // First rectangle's axes only; rerun the cases where that matters.
    apb_access(1'b1, ADDR_MODE, '0);
    apb_access(1'b0, ADDR_MODE, '0);
    run_directed(6, 11);
    run_random(RANDOM_PER_PHASE);
    mode_phase(ADDR_MODE, '1);
    mode_phase(ADDR_MODE, {{(PDATA_W-1){1'b1}}, 1'b0});
    mode_phase(ADDR_SPARE, 32'h1);
    mode_phase(ADDR_MODE, 32'h1);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[oriented_rectangle_overlap_test_top.f]
hw/rtl/orot_pkg.sv
hw/rtl/orot_axis.sv
hw/rtl/oriented_rectangle_overlap_test_top.sv
sim/overlap_monitor.sv
sim/tb_oriented_rectangle_overlap_test_top.sv
